// File: design/touch_event_packet_bridge_defines.svh
// Assertion macros for the touch event packet bridge.
// Each use names its label, the property and the message.
`ifndef TOUCH_EVENT_PACKET_BRIDGE_DEFINES_SVH
`define TOUCH_EVENT_PACKET_BRIDGE_DEFINES_SVH

`ifndef SYNTHESIS
`define TEPB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TEPB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TEPB_ASSERT(lbl, prop, msg)
`define TEPB_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// File: design/tepb_pkg.sv
package tepb_pkg;

  localparam int QUEUE_DEPTH = 128;
  localparam int QAW         = $clog2(QUEUE_DEPTH);
  localparam int QFW         = $clog2(QUEUE_DEPTH + 1);
  localparam int PKT_BYTES   = 10;
  localparam int PCW         = $clog2(PKT_BYTES);

  // input item modes
  localparam logic [1:0] MODE_TOUCH = 2'd0;
  localparam logic [1:0] MODE_CMD   = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // protocol bytes
  localparam logic [7:0] BYTE_SYNC  = 8'h55;  // 'U'
  localparam logic [7:0] BYTE_TOUCH = 8'h54;  // 'T'
  localparam logic [7:0] BYTE_ACK   = 8'h41;  // 'A'
  localparam logic [7:0] BYTE_ID    = 8'h49;  // 'I'
  localparam logic [7:0] BYTE_OWNER = 8'h4F;  // 'O'
  localparam logic [7:0] CSUM_SEED  = 8'hAA;

  // host commands
  localparam logic [7:0] CMD_ID     = 8'h69;  // 'i'
  localparam logic [7:0] CMD_OWNER  = 8'h6F;  // 'o'
  localparam logic [7:0] CMD_MODE   = 8'h6D;  // 'm'
  localparam logic [7:0] CMD_REPORT = 8'h72;  // 'r'

  localparam logic [7:0]  EV_PRESS   = 8'h01;
  localparam logic [7:0]  EV_MOVE    = 8'h02;
  localparam logic [7:0]  EV_RELEASE = 8'h04;
  localparam logic [15:0] PRESS_FULL = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_PRESS   = 2'd0,
    KIND_MOVE    = 2'd1,
    KIND_RELEASE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PEND_NONE     = 2'd0,
    PEND_REPLY    = 2'd1,
    PEND_ONLY_ACK = 2'd2
  } pend_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic        pressed;
    logic [7:0]  command_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] packet_byte;
    logic       last_byte;
    logic       nothing_ready;
    logic       data_ready;
  } out_word_t;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    kind_t       kind;
  } evq_entry_t;

  typedef struct packed {
    logic nonempty;
    logic multi;     // more than one entry
    logic full;
  } evq_stat_t;

  typedef logic [PKT_BYTES-1:0][7:0] pkt_t;

  typedef struct packed {
    logic load;
    logic nothing;
    logic ready;
    pkt_t pkt;
  } tx_load_t;

  function automatic logic [QAW-1:0] ptr_inc(input logic [QAW-1:0] p);
    ptr_inc = (p == QAW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // sync, command, seven payload bytes, checksum
  function automatic pkt_t build_pkt(input logic [7:0] cmd, input logic [7:0] ev,
                                     input logic [15:0] x, input logic [15:0] y,
                                     input logic [15:0] pr);
    pkt_t p;
    p[0] = BYTE_SYNC;
    p[1] = cmd;
    p[2] = ev;
    p[3] = x[7:0];
    p[4] = x[15:8];
    p[5] = y[7:0];
    p[6] = y[15:8];
    p[7] = pr[7:0];
    p[8] = pr[15:8];
    p[9] = ((CSUM_SEED + p[0]) + (p[1] + p[2])) + ((p[3] + p[4]) + (p[5] + p[6]))
           + (p[7] + p[8]);
    build_pkt = p;
  endfunction

  function automatic logic [7:0] ev_bits(input kind_t k);
    case (k)
      KIND_PRESS:   ev_bits = EV_PRESS;
      KIND_MOVE:    ev_bits = EV_MOVE;
      default:      ev_bits = EV_RELEASE;
    endcase
  endfunction

endpackage

// File: design/tepb_ram.sv
module tepb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/tepb_evq.sv
`include "touch_event_packet_bridge_defines.svh"

module tepb_evq import tepb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  evq_entry_t push_entry,
  input  logic       fetch,       // read head entry, data next cycle
  input  logic       pop,
  output evq_stat_t  stat,
  output evq_entry_t head_entry
);

  logic [QAW-1:0] head_r, head_nxt;
  logic [QAW-1:0] tail_r, tail_nxt;
  logic [QFW-1:0] fill_r, fill_nxt;
  logic [$bits(evq_entry_t)-1:0] rd_data;

  assign stat.nonempty = (fill_r != '0);
  assign stat.multi    = (fill_r > QFW'(1));
  assign stat.full     = (fill_r == QFW'(QUEUE_DEPTH));
  assign head_entry    = evq_entry_t'(rd_data);

  always_comb begin
    head_nxt = pop  ? ptr_inc(head_r) : head_r;
    tail_nxt = push ? ptr_inc(tail_r) : tail_r;
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
    end
  end

  tepb_ram #(
    .WIDTH ($bits(evq_entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (push),
    .waddr (tail_r),
    .wdata (push_entry),
    .re    (fetch),
    .raddr (head_r),
    .rdata (rd_data)
  );

  `TEPB_ASSERT(a_no_push_full, push |-> !stat.full, "push into full event queue")
  `TEPB_ASSERT(a_no_pop_empty, pop |-> stat.nonempty, "pop from empty event queue")
  `TEPB_ASSERT(a_fill_up, (push && !pop) |=> (fill_r == $past(fill_r) + 1'b1), "fill count slip")

endmodule

// File: design/tepb_tx.sv
`include "touch_event_packet_bridge_defines.svh"

module tepb_tx import tepb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  tx_load_t  ld,
  output logic      tx_free,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam logic [PCW-1:0] LAST_IDX = PCW'(PKT_BYTES - 1);

  logic           busy_r, busy_nxt;
  logic           nothing_r, nothing_nxt;
  logic           ready_r, ready_nxt;
  logic [PCW-1:0] cnt_r, cnt_nxt;
  pkt_t           pkt_r, pkt_nxt;
  logic           take;
  logic           done_word;

  assign take      = busy_r && !out_stall;
  assign done_word = take && (nothing_r || (cnt_r == LAST_IDX));
  assign tx_free   = !busy_r || done_word;

  assign out_valid              = busy_r;
  assign out_word.packet_byte   = pkt_r[0];
  assign out_word.last_byte     = !nothing_r && (cnt_r == LAST_IDX);
  assign out_word.nothing_ready = nothing_r;
  assign out_word.data_ready    = ready_r;

  always_comb begin
    busy_nxt    = busy_r;
    nothing_nxt = nothing_r;
    ready_nxt   = ready_r;
    cnt_nxt     = cnt_r;
    pkt_nxt     = pkt_r;
    if (ld.load) begin
      busy_nxt    = 1'b1;
      nothing_nxt = ld.nothing;
      ready_nxt   = ld.ready;
      cnt_nxt     = '0;
      pkt_nxt     = ld.pkt;
    end else if (done_word) begin
      busy_nxt = 1'b0;
    end else if (take) begin
      cnt_nxt = cnt_r + 1'b1;
      pkt_nxt = {8'h00, pkt_r[PKT_BYTES-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    nothing_r <= nothing_nxt;
    ready_r   <= ready_nxt;
    cnt_r     <= cnt_nxt;
    pkt_r     <= pkt_nxt;
  end

  `TEPB_ASSERT(a_load_when_free, ld.load |-> tx_free, "packet loaded over a busy serializer")
  `TEPB_ASSERT(a_cnt_range, busy_r |-> (cnt_r <= LAST_IDX), "byte index past packet end")
  `TEPB_ASSERT(a_drop_after_last, (done_word && !ld.load) |=> !busy_r, "valid held after last word")

endmodule

// File: design/touch_event_packet_bridge.sv
// Path: a reply or ack read passes the input register, then the serializer
//   register; a touch event read also passes the registered event queue read.
// Throughput: one touch or command word per cycle unless a read is held; a read holds
//   the serializer for 10 words (1 if nothing ready), one per cycle unless stalled.
// Reset: synchronous, active low; clears queue pointers, tip state, pending reply,
//   device_open and handshake state. Event queue storage is not cleared.
`include "touch_event_packet_bridge_defines.svh"

module touch_event_packet_bridge import tepb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  // input channel
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  // result channel
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word,
  // config
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);

  // Input register: one word waits here until it can be handled. Touch and
  // command words leave the same cycle; a read waits for the serializer and,
  // for a touch event, for the queue head fetch.
  in_word_t item_r;
  logic     item_vld_r, item_vld_nxt;
  logic     accept_in;
  logic     consume;

  logic     open_r;
  logic     touch_down_r, touch_down_nxt;
  pend_t    pend_r, pend_nxt;
  logic [7:0] reply_r, reply_nxt;
  logic     fetch_r, fetch_nxt;     // head entry is sitting in the queue read register

  // event queue
  logic       q_push;
  evq_entry_t q_entry;
  logic       q_fetch;
  logic       q_pop;
  evq_stat_t  q_stat;
  evq_entry_t q_head;

  // serializer
  tx_load_t tx_ld;
  logic     tx_free;

  assign in_stall  = item_vld_r && !consume;
  assign accept_in = in_valid && !in_stall;

  always_comb begin
    item_vld_nxt = item_vld_r;
    if (accept_in) begin
      item_vld_nxt = 1'b1;
    end else if (consume) begin
      item_vld_nxt = 1'b0;
    end
  end

  // Main decode of the held word
  always_comb begin
    consume        = 1'b0;
    touch_down_nxt = touch_down_r;
    pend_nxt       = pend_r;
    reply_nxt      = reply_r;
    fetch_nxt      = fetch_r;
    q_push         = 1'b0;
    q_fetch        = 1'b0;
    q_pop          = 1'b0;
    q_entry.x      = item_r.pos_x;
    q_entry.y      = item_r.pos_y;
    q_entry.kind   = KIND_RELEASE;
    tx_ld.load     = 1'b0;
    tx_ld.nothing  = 1'b0;
    tx_ld.ready    = 1'b0;
    tx_ld.pkt      = build_pkt(BYTE_ACK, 8'h00, 16'h0000, 16'h0000, 16'h0000);

    if (item_vld_r) begin
      case (item_r.mode)
        MODE_TOUCH: begin
          consume = 1'b1;
          // dropped while closed or full; tip state untouched then
          if (open_r && !q_stat.full) begin
            q_push = 1'b1;
            if (item_r.pressed) begin
              q_entry.kind   = touch_down_r ? KIND_MOVE : KIND_PRESS;
              touch_down_nxt = 1'b1;
            end else begin
              q_entry.kind   = KIND_RELEASE;
              touch_down_nxt = 1'b0;
            end
          end
        end

        MODE_CMD: begin
          consume = 1'b1;
          case (item_r.command_byte)
            CMD_ID: begin
              reply_nxt = BYTE_ID;
              pend_nxt  = PEND_REPLY;
            end
            CMD_OWNER: begin
              reply_nxt = BYTE_OWNER;
              pend_nxt  = PEND_REPLY;
            end
            CMD_MODE, CMD_REPORT: begin
              pend_nxt = PEND_ONLY_ACK;
            end
            default: ;  // unknown command, ignored
          endcase
        end

        MODE_READ: begin
          case (pend_r)
            PEND_REPLY: begin
              if (tx_free) begin
                consume     = 1'b1;
                tx_ld.load  = 1'b1;
                tx_ld.ready = 1'b1;  // ack still owed
                tx_ld.pkt   = build_pkt(reply_r, 8'h00, 16'h0000, 16'h0000, 16'h0000);
                pend_nxt    = PEND_ONLY_ACK;
              end
            end
            PEND_ONLY_ACK: begin
              if (tx_free) begin
                consume     = 1'b1;
                tx_ld.load  = 1'b1;
                tx_ld.ready = q_stat.nonempty;
                pend_nxt    = PEND_NONE;
              end
            end
            PEND_NONE: begin
              if (q_stat.nonempty) begin
                if (!fetch_r) begin
                  q_fetch   = 1'b1;
                  fetch_nxt = 1'b1;
                end else if (tx_free) begin
                  consume     = 1'b1;
                  q_pop       = 1'b1;
                  fetch_nxt   = 1'b0;
                  tx_ld.load  = 1'b1;
                  tx_ld.ready = q_stat.multi;
                  tx_ld.pkt   = build_pkt(BYTE_TOUCH, ev_bits(q_head.kind), q_head.x,
                                          q_head.y,
                                          (q_head.kind == KIND_RELEASE) ? 16'h0000
                                                                        : PRESS_FULL);
                end
              end else if (tx_free) begin
                // nothing ready: single all-zero word with the flag set
                consume       = 1'b1;
                tx_ld.load    = 1'b1;
                tx_ld.nothing = 1'b1;
                tx_ld.pkt     = '0;
              end
            end
            default: begin
              consume = 1'b1;
            end
          endcase
        end

        default: begin
          consume = 1'b1;  // unused mode, no result
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r   <= 1'b0;
      open_r       <= 1'b0;
      touch_down_r <= 1'b0;
      pend_r       <= PEND_NONE;
      reply_r      <= 8'h00;
      fetch_r      <= 1'b0;
    end else begin
      item_vld_r   <= item_vld_nxt;
      touch_down_r <= touch_down_nxt;
      pend_r       <= pend_nxt;
      reply_r      <= reply_nxt;
      fetch_r      <= fetch_nxt;
      if (cfg_wr_en) begin
        open_r <= cfg_wr_data;
      end
    end
    if (accept_in) begin
      item_r <= in_word;
    end
  end

  tepb_evq u_evq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .fetch      (q_fetch),
    .pop        (q_pop),
    .stat       (q_stat),
    .head_entry (q_head)
  );

  tepb_tx u_tx (
    .clk       (clk),
    .rst_n     (rst_n),
    .ld        (tx_ld),
    .tx_free   (tx_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  `TEPB_ASSERT(a_pop_after_fetch, q_pop |-> fetch_r, "event popped without head fetch")
  `TEPB_ASSERT(a_fetch_holds, (fetch_r && !consume) |=> fetch_r, "head fetch lost before use")
  `TEPB_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (!item_vld_r && !fetch_r), "reset left work held")

endmodule

// File: verif/tb_touch_event_packet_bridge.sv
module tb_touch_event_packet_bridge;
  timeunit 1ns;
  timeprecision 1ps;
  import tepb_pkg::*;

  // --------------------------------------------------------------------------
  // Run parameters
  // --------------------------------------------------------------------------
  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 12;
  // A read passes the input register and the serializer, plus the event queue read for
  // a touch event; the quiet cycles of DRAIN_CYCLES cover anything still in flight.
  localparam int DRAIN_CYCLES   = 20;
  // Longest correct quiet stretch is a long sender gap or a long receiver
  // stall plus the path through the block; this is many times that.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES  = 3;
  localparam int PHASE_ITEMS    = 6;
  localparam int FULL_READS     = 4;

  // mode 3 is unused by the block and must be ignored
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the bridge state and holds the packet bytes expected
  // from each accepted read, oldest first.
  // --------------------------------------------------------------------------
  class packet_scoreboard;
    logic [15:0] ev_x [QUEUE_DEPTH];
    logic [15:0] ev_y [QUEUE_DEPTH];
    kind_t       ev_kind [QUEUE_DEPTH];
    int unsigned fill;
    int unsigned head;
    bit          tip_down;
    pend_t       pend;
    logic [7:0]  reply_code;
    bit          dev_open;
    out_word_t   expected_bytes[$];
    int          mismatches;

    function new();
      fill       = 0;
      head       = 0;
      tip_down   = 1'b0;
      pend       = PEND_NONE;
      reply_code = '0;
      dev_open   = 1'b0;
      mismatches = 0;
    endfunction

    function void set_open(bit v);
      dev_open = v;
    endfunction

    // Update the state for one accepted input word; reads queue their bytes.
    function void note_word(in_word_t w);
      logic [7:0]  pkt [PKT_BYTES];
      logic [7:0]  sum;
      logic [15:0] pr;
      int unsigned slot;
      bit          ready;
      out_word_t   o;
      case (w.mode)
        MODE_TOUCH: begin
          // closed device or full queue: sample dropped, tip state kept
          if (dev_open && fill < QUEUE_DEPTH) begin
            slot = (head + fill) % QUEUE_DEPTH;
            ev_x[slot] = w.pos_x;
            ev_y[slot] = w.pos_y;
            if (w.pressed) begin
              ev_kind[slot] = tip_down ? KIND_MOVE : KIND_PRESS;
              tip_down = 1'b1;
            end else begin
              ev_kind[slot] = KIND_RELEASE;
              tip_down = 1'b0;
            end
            fill++;
          end
        end
        MODE_CMD: begin
          case (w.command_byte)
            CMD_ID: begin
              reply_code = BYTE_ID;
              pend = PEND_REPLY;
            end
            CMD_OWNER: begin
              reply_code = BYTE_OWNER;
              pend = PEND_REPLY;
            end
            CMD_MODE, CMD_REPORT: pend = PEND_ONLY_ACK;
            default: ;
          endcase
        end
        MODE_READ: begin
          foreach (pkt[i]) pkt[i] = '0;
          if (pend == PEND_REPLY) begin
            pkt[1] = reply_code;
            pend = PEND_ONLY_ACK;
          end else if (pend == PEND_ONLY_ACK) begin
            pkt[1] = BYTE_ACK;
            pend = PEND_NONE;
          end else if (fill > 0) begin
            pr = (ev_kind[head] == KIND_RELEASE) ? 16'h0000 : PRESS_FULL;
            pkt[1] = BYTE_TOUCH;
            case (ev_kind[head])
              KIND_PRESS: pkt[2] = EV_PRESS;
              KIND_MOVE:  pkt[2] = EV_MOVE;
              default:    pkt[2] = EV_RELEASE;
            endcase
            pkt[3] = ev_x[head][7:0];
            pkt[4] = ev_x[head][15:8];
            pkt[5] = ev_y[head][7:0];
            pkt[6] = ev_y[head][15:8];
            pkt[7] = pr[7:0];
            pkt[8] = pr[15:8];
            head = (head + 1) % QUEUE_DEPTH;
            fill--;
          end else begin
            // nothing ready: one lone word
            o.packet_byte   = '0;
            o.last_byte     = 1'b0;
            o.nothing_ready = 1'b1;
            o.data_ready    = 1'b0;
            expected_bytes.push_back(o);
            return;
          end
          ready  = (fill > 0) || (pend != PEND_NONE);
          pkt[0] = BYTE_SYNC;
          sum    = CSUM_SEED;
          for (int i = 0; i < PKT_BYTES - 1; i++) sum = sum + pkt[i];
          pkt[PKT_BYTES-1] = sum;
          for (int i = 0; i < PKT_BYTES; i++) begin
            o.packet_byte   = pkt[i];
            o.last_byte     = (i == PKT_BYTES - 1);
            o.nothing_ready = 1'b0;
            o.data_ready    = ready;
            expected_bytes.push_back(o);
          end
        end
        default: ;
      endcase
    endfunction

    task flag_mismatch(string what);
      mismatches++;
      $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // Compare one accepted output word against the oldest expected byte.
    task check_word(out_word_t got);
      out_word_t want;
      if (expected_bytes.size() == 0) begin
        flag_mismatch($sformatf("unexpected output word %h", got));
        return;
      end
      want = expected_bytes.pop_front();
      if (got.packet_byte !== want.packet_byte)
        flag_mismatch($sformatf("packet_byte got %h want %h",
                                got.packet_byte, want.packet_byte));
      if (got.last_byte !== want.last_byte)
        flag_mismatch($sformatf("last_byte got %b want %b",
                                got.last_byte, want.last_byte));
      if (got.nothing_ready !== want.nothing_ready)
        flag_mismatch($sformatf("nothing_ready got %b want %b",
                                got.nothing_ready, want.nothing_ready));
      if (got.data_ready !== want.data_ready)
        flag_mismatch($sformatf("data_ready got %b want %b",
                                got.data_ready, want.data_ready));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;
  logic      cfg_wr_en;
  logic      cfg_wr_data;

  touch_event_packet_bridge dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  packet_scoreboard sb;

  // calm flags switch off idling on one side for a whole phase
  bit tx_calm = 1'b0;
  bit rx_calm = 1'b0;
  int stall_left = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Receiver back-pressure: mostly short stalls, now and then a long one.
  // Driven on the falling edge so the DUT sees it settled at the rising edge.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (!rx_calm && $urandom_range(0, 99) < 25) begin
      out_stall <= 1'b1;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 29)
                                               : $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result monitor: every accepted word goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_word(out_word);
  end

  // Watchdog: ends the run if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no handshake for %0d cycles", $time, quiet_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Sender gap: usually none or short, sometimes long.
  function automatic int pick_gap();
    int r;
    if (tx_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Word of the given mode; fields the mode does not use carry random junk.
  function automatic in_word_t make_word(logic [1:0] mode);
    logic [63:0] r;
    in_word_t    w;
    r = {$urandom, $urandom};
    w = r[$bits(in_word_t)-1:0];
    w.mode = mode;
    return w;
  endfunction

  // Mostly the four known commands, sometimes an arbitrary byte.
  function automatic logic [7:0] pick_cmd();
    case ($urandom_range(0, 5))
      0:       return CMD_ID;
      1:       return CMD_OWNER;
      2:       return CMD_MODE;
      3:       return CMD_REPORT;
      default: return 8'($urandom);
    endcase
  endfunction

  // Present one word, hold it until accepted, then idle for a random gap.
  // With no gap, valid simply stays high into the next word.
  task automatic send_word(input in_word_t w);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(w);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_touch(input logic [15:0] x, input logic [15:0] y, input bit p);
    in_word_t w;
    w = make_word(MODE_TOUCH);
    w.pos_x   = x;
    w.pos_y   = y;
    w.pressed = p;
    send_word(w);
  endtask

  task automatic send_cmd(input logic [7:0] c);
    in_word_t w;
    w = make_word(MODE_CMD);
    w.command_byte = c;
    send_word(w);
  endtask

  task automatic send_read();
    send_word(make_word(MODE_READ));
  endtask

  // Drop valid, wait for every expected byte, then let the pipe go quiet.
  // Touch and command words leave nothing to wait on, hence the fixed tail.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // device_open write; only ever called with the block idle
  task automatic write_open(input bit v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_open(v);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int count;
    int moves;
    int n;
    sb          = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_word     = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed: device still closed after reset ----
    send_read();                              // empty: nothing-ready word
    send_touch(16'hFFFF, 16'hFFFF, 1'b1);     // closed: ignored, tip stays up
    send_read();                              // still empty
    send_word(make_word(MODE_UNUSED));        // unused mode: no effect
    settle();
    write_open(1'b1);

    // ---- directed: replies, acks and their priority ----
    send_cmd(CMD_ID);
    send_read();                              // 'I', more to come
    send_read();                              // 'A', nothing left
    send_cmd(CMD_OWNER);
    send_cmd(CMD_MODE);                       // overrides the pending reply
    send_read();                              // 'A' only
    send_cmd(CMD_REPORT);
    send_cmd(8'hFF);                          // unknown codes: ignored
    send_cmd(8'h00);
    send_read();                              // 'A'

    // ---- directed: a full stroke at the coordinate extremes ----
    send_touch(16'h0000, 16'h0000, 1'b1);     // press
    send_touch(16'hFFFF, 16'hFFFF, 1'b1);     // move
    send_touch(16'h1234, 16'hABCD, 1'b0);     // release, zero pressure
    send_cmd(CMD_OWNER);
    send_read();                              // reply beats queued events
    send_read();                              // then the ack
    send_read();                              // press event
    send_read();                              // move event
    send_read();                              // release event, queue empty
    send_read();                              // nothing ready

    // ---- random phases, each with its own device_open and idling mix ----
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      tx_calm = (ph == 1) || ($urandom_range(0, 4) == 0);
      rx_calm = (ph == 2) || ($urandom_range(0, 4) == 0);
      write_open(ph % 3 != 2);
      count = 0;
      while (count < PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            // well-formed stroke: press, some moves, release
            moves = $urandom_range(0, 4);
            send_touch(16'($urandom), 16'($urandom), 1'b1);
            repeat (moves) send_touch(16'($urandom), 16'($urandom), 1'b1);
            send_touch(16'($urandom), 16'($urandom), 1'b0);
            count += moves + 2;
          end
          4, 5: begin
            send_cmd(pick_cmd());
            count++;
          end
          6, 7, 8: begin
            n = $urandom_range(1, 3);
            repeat (n) send_read();
            count += n;
          end
          default: begin
            // noise: stray touch sample with random tip bit, or unused mode
            if ($urandom_range(0, 1) == 0) begin
              send_touch(16'($urandom), 16'($urandom), 1'($urandom));
              count++;
            end else begin
              send_word(make_word(MODE_UNUSED));
            end
          end
        endcase
      end
    end

    // ---- overflow: top the queue up just past full, then read a few ----
    // Samples beyond full are dropped and must leave the tip state alone.
    settle();
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    write_open(1'b1);
    n = QUEUE_DEPTH + 2 - int'(sb.fill);
    repeat (n) send_touch(16'($urandom), 16'($urandom), 1'($urandom));
    send_cmd(CMD_ID);
    repeat (FULL_READS) send_read();
    send_touch(16'($urandom), 16'($urandom), 1'b1);
    send_read();
    send_read();

    settle();
    if (sb.mismatches == 0 && sb.expected_bytes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
